### hdl/rrnh_pkg.sv
// Shared types, widths and register codes of the ray versus rectangle hit block.
`default_nettype none
package rrnh_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;

  localparam int CW   = COORD_WIDTH;
  localparam int SW   = 12;                             // rectangle size field
  localparam int OUTW = 24;                             // result coordinate field
  localparam int EW   = ((CW > SW) ? CW : SW) + 1;      // edge corner coordinate
  localparam int OW   = EW + 1;                         // ray point minus edge corner
  localparam int DW   = CW + 1;                         // ray delta
  localparam int PTW  = OW + SW + 1;                    // raw t numerator
  localparam int PDW  = DW + SW + 1;                    // raw denominator
  localparam int NUW  = DW + OW + 1;                    // raw u numerator
  localparam int FW   = CW + SW;                        // normalized fraction terms
  localparam int PW   = FW + DW;                        // numerator times ray delta
  localparam int QW   = DW + FRAC_BITS + 1;             // fixed point offset quotient
  localparam int NW   = PW + FRAC_BITS + 2;             // rounding dividend
  localparam int RW   = ((QW > OUTW) ? QW : OUTW) + 1;  // output sum width
  localparam int CNW  = $clog2(QW);                     // divide step counter
  localparam int QD   = 4;                              // edge queue depth
  localparam int QAW  = $clog2(QD);
  localparam int CFG_AW = 2;

  typedef enum logic [CFG_AW-1:0] {
    REG_START_X = 2'd0,
    REG_START_Y = 2'd1,
    REG_END_X   = 2'd2,
    REG_END_Y   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] rect_left;
    logic signed [CW-1:0] rect_top;
    logic [SW-1:0]        rect_width;
    logic [SW-1:0]        rect_height;
    logic                 last_rect;
  } in_t;

  typedef struct packed {
    logic                   hit_found;
    logic signed [OUTW-1:0] end_x;
    logic signed [OUTW-1:0] end_y;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
  } ray_t;

  typedef struct packed {
    logic          hit;
    logic [FW-1:0] num;
    logic [FW-1:0] den;
    logic          last;
  } edge_item_t;

endpackage
`default_nettype wire

### hdl/rrnh_front.sv
// Front end: holds a rectangle and tests each of its edges against the ray.
`default_nettype none
module rrnh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  rrnh_pkg::ray_t     ray,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrnh_pkg::in_t      in_data,
  output logic               push_valid,
  output rrnh_pkg::edge_item_t push_data,
  input  logic               q_full
);
  import rrnh_pkg::*;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_LEFT   = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_sel_t;

  in_t       rect_r;
  logic      busy_r;
  edge_sel_t edge_r;
  edge_sel_t edge_nxt;

  logic                  s1_valid_r;
  logic                  s1_last_r;
  logic signed [PTW-1:0] s1_nt_r;
  logic signed [PDW-1:0] s1_d_r;
  logic signed [NUW-1:0] s1_nu_r;

  logic signed [OW-1:0] x1e, y1e, le, te, re, be, x3, y3, ox, oy, a_c;
  logic signed [DW-1:0] dx, dy, dd_c;
  logic signed [SW:0]   s_c;
  logic signed [PTW-1:0] nt_c;
  logic signed [PDW-1:0] d_c;
  logic signed [NUW-1:0] nu_c;
  logic                  issue;
  logic                  horiz;

  logic signed [NUW-1:0] nt_x, d_x, nu_x, ntn, dn, nun;
  logic                  neg;

  assign in_stall = busy_r;
  assign issue    = busy_r && !(s1_valid_r && q_full);

  always_comb begin
    x1e = $signed({{(OW-CW){ray.x1[CW-1]}}, ray.x1});
    y1e = $signed({{(OW-CW){ray.y1[CW-1]}}, ray.y1});
    dx  = $signed({ray.x1[CW-1], ray.x1}) - $signed({ray.x2[CW-1], ray.x2});
    dy  = $signed({ray.y1[CW-1], ray.y1}) - $signed({ray.y2[CW-1], ray.y2});
    le  = $signed({{(OW-CW){rect_r.rect_left[CW-1]}}, rect_r.rect_left});
    te  = $signed({{(OW-CW){rect_r.rect_top[CW-1]}}, rect_r.rect_top});
    re  = le + $signed({{(OW-SW){1'b0}}, rect_r.rect_width});
    be  = te + $signed({{(OW-SW){1'b0}}, rect_r.rect_height});
    case (edge_r)
      EDGE_TOP:    begin x3 = le; y3 = te; horiz = 1'b1; edge_nxt = EDGE_LEFT;   end
      EDGE_LEFT:   begin x3 = le; y3 = te; horiz = 1'b0; edge_nxt = EDGE_RIGHT;  end
      EDGE_RIGHT:  begin x3 = re; y3 = te; horiz = 1'b0; edge_nxt = EDGE_BOTTOM; end
      EDGE_BOTTOM: begin x3 = le; y3 = be; horiz = 1'b1; edge_nxt = EDGE_TOP;    end
      default:     begin x3 = le; y3 = te; horiz = 1'b1; edge_nxt = EDGE_TOP;    end
    endcase
    ox = x1e - x3;
    oy = y1e - y3;
    // Horizontal edge: ex = -w, ey = 0. Vertical edge: ex = 0, ey = -h.
    if (horiz) begin
      a_c  = oy;
      s_c  = $signed({1'b0, rect_r.rect_width});
      dd_c = dy;
    end else begin
      a_c  = -ox;
      s_c  = $signed({1'b0, rect_r.rect_height});
      dd_c = -dx;
    end
    nt_c = PTW'(a_c) * PTW'(s_c);
    d_c  = PDW'(dd_c) * PDW'(s_c);
    nu_c = NUW'(dy) * NUW'(ox) - NUW'(dx) * NUW'(oy);
  end

  // Normalize the sign of the denominator and apply the strict bounds.
  always_comb begin
    nt_x = NUW'(s1_nt_r);
    d_x  = NUW'(s1_d_r);
    nu_x = s1_nu_r;
    neg  = s1_d_r < 0;
    ntn  = neg ? -nt_x : nt_x;
    dn   = neg ? -d_x  : d_x;
    nun  = neg ? -nu_x : nu_x;
    push_data.hit  = (s1_d_r != 0) && (ntn > 0) && (ntn < dn) && (nun > 0) && (nun < dn);
    push_data.num  = ntn[FW-1:0];
    push_data.den  = dn[FW-1:0];
    push_data.last = s1_last_r;
  end

  assign push_valid = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      edge_r     <= EDGE_TOP;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_valid && !busy_r) begin
        busy_r <= 1'b1;
        edge_r <= EDGE_TOP;
      end else if (issue) begin
        edge_r <= edge_nxt;
        if (edge_r == EDGE_BOTTOM) begin
          busy_r <= 1'b0;
        end
      end
      s1_valid_r <= issue || (s1_valid_r && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !busy_r) begin
      rect_r <= in_data;
    end
    if (issue) begin
      s1_nt_r   <= nt_c;
      s1_d_r    <= d_c;
      s1_nu_r   <= nu_c;
      s1_last_r <= rect_r.last_rect && (edge_r == EDGE_BOTTOM);
    end
  end

endmodule
`default_nettype wire

### hdl/rrnh_queue.sv
// Short queue of edge test results between the front and back ends.
`default_nettype none
module rrnh_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rrnh_pkg::edge_item_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output rrnh_pkg::edge_item_t pop_data
);
  import rrnh_pkg::*;

  edge_item_t       mem_r [QD];
  logic [QAW-1:0]   wr_r;
  logic [QAW-1:0]   rd_r;
  logic [QAW:0]     cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = cnt_r == (QAW+1)'(QD);
  assign valid    = cnt_r != '0;
  assign pop_data = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= rd_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hdl/rrnh_back.sv
// Back end: running minimum of hit fractions and the final rounded hit point.
`default_nettype none
module rrnh_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrnh_pkg::ray_t       ray,
  input  logic                 q_valid,
  input  rrnh_pkg::edge_item_t q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rrnh_pkg::out_t       out_data
);
  import rrnh_pkg::*;

  typedef enum logic [2:0] {
    B_POP, B_MUL, B_UPD, B_PMUL, B_INIT, B_DIV, B_FIN, B_OUT
  } state_t;

  state_t          state_r;
  edge_item_t      ent_r;
  logic [FW-1:0]   bn_r;
  logic [FW-1:0]   bd_r;
  logic            have_r;
  logic [2*FW-1:0] pa_r;
  logic [2*FW-1:0] pb_r;
  logic            axis_r;
  logic            sign_r;
  logic [PW-1:0]   p_r;
  logic [FW:0]     rem_r;
  logic [QW-1:0]   q_r;
  logic [CNW-1:0]  cnt_r;
  logic [OUTW-1:0] res_x_r;
  logic            out_valid_r;
  out_t            out_data_r;

  logic signed [DW-1:0] diff;
  logic [DW-1:0]        mag;
  logic [NW-1:0]        dividend;
  logic [FW+1:0]        trial;
  logic [FW+1:0]        divisor;
  logic                 ge;
  logic signed [RW-1:0] base;
  logic signed [RW-1:0] coord;
  logic signed [RW-1:0] end_xe;
  logic signed [RW-1:0] end_ye;
  logic signed [CW-1:0] origin;

  assign q_pop     = (state_r == B_POP) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    if (axis_r) begin
      diff   = $signed({ray.y2[CW-1], ray.y2}) - $signed({ray.y1[CW-1], ray.y1});
      origin = ray.y1;
    end else begin
      diff   = $signed({ray.x2[CW-1], ray.x2}) - $signed({ray.x1[CW-1], ray.x1});
      origin = ray.x1;
    end
    mag      = diff < 0 ? DW'(-diff) : DW'(diff);
    // Round to nearest: floor((p * 2^(F+1) + den) / (2 * den)).
    dividend = (NW'(p_r) << (FRAC_BITS + 1)) + NW'(bd_r);
    divisor  = {1'b0, bd_r, 1'b0};
    trial    = {rem_r, q_r[QW-1]};
    ge       = trial >= divisor;
    base     = RW'(origin) <<< FRAC_BITS;
    coord    = sign_r ? base - $signed(RW'(q_r)) : base + $signed(RW'(q_r));
    end_xe   = RW'(ray.x2) <<< FRAC_BITS;
    end_ye   = RW'(ray.y2) <<< FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_POP;
      bn_r        <= '0;
      bd_r        <= FW'(1);
      have_r      <= 1'b0;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != B_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_POP: begin
          if (q_valid) begin
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          state_r <= B_UPD;
        end
        B_UPD: begin
          if (ent_r.hit && (!have_r || pa_r < pb_r)) begin
            bn_r   <= ent_r.num;
            bd_r   <= ent_r.den;
            have_r <= 1'b1;
          end
          axis_r  <= 1'b0;
          state_r <= ent_r.last ? B_PMUL : B_POP;
        end
        B_PMUL: begin
          state_r <= have_r ? B_INIT : B_OUT;
        end
        B_INIT: begin
          cnt_r   <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNW'(QW - 1)) begin
            state_r <= B_FIN;
          end
        end
        B_FIN: begin
          if (axis_r) begin
            state_r <= B_OUT;
          end else begin
            axis_r  <= 1'b1;
            state_r <= B_PMUL;
          end
        end
        B_OUT: begin
          // Hold until the output register is free, then clear the query.
          if (!out_valid_r || !out_stall) begin
            out_valid_r          <= 1'b1;
            out_data_r.hit_found <= have_r;
            if (have_r) begin
              out_data_r.end_x <= $signed(res_x_r);
              out_data_r.end_y <= $signed(coord[OUTW-1:0]);
            end else begin
              out_data_r.end_x <= $signed(end_xe[OUTW-1:0]);
              out_data_r.end_y <= $signed(end_ye[OUTW-1:0]);
            end
            bn_r    <= '0;
            bd_r    <= FW'(1);
            have_r  <= 1'b0;
            state_r <= B_POP;
          end
        end
        default: state_r <= B_POP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_POP: begin
        if (q_valid) begin
          ent_r <= q_data;
        end
      end
      B_MUL: begin
        pa_r <= ent_r.num * bd_r;
        pb_r <= bn_r * ent_r.den;
      end
      B_PMUL: begin
        p_r    <= bn_r * PW'(mag);
        sign_r <= diff < 0;
      end
      B_INIT: begin
        rem_r <= dividend[NW-1:QW];
        q_r   <= dividend[QW-1:0];
      end
      B_DIV: begin
        rem_r <= ge ? (FW+1)'(trial - divisor) : trial[FW:0];
        q_r   <= {q_r[QW-2:0], ge};
      end
      B_FIN: begin
        if (!axis_r) begin
          res_x_r <= coord[OUTW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### hdl/ray_rect_nearest_hit.sv
// Top level: configuration registers, edge test front end, queue and hit point back end.
//
//   channel | ports                               | carries
//   --------+-------------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data         | one rectangle per transfer
//   result  | out_valid, out_stall, out_data      | hit flag and end point, Q.8
//   config  | cfg_we, cfg_addr, cfg_data          | ray start and end coordinates
//
// The front end takes a rectangle when idle, then tests one edge per cycle unless
// the queue is full, holding in_stall high until every edge is issued, so a new
// rectangle is not taken before then. The back end steps through its pop, multiply
// and update states for each edge on its shared cross-multiply compare; if the query had a hit,
// its last rectangle adds a rounding divide per axis, x then y, one quotient bit per cycle,
// then the output state; without a hit it skips the divides and goes to output.
// Synchronous active-low reset clears the queue, the running minimum and both valids.
// A stalled result holds in the output register while the front end keeps taking
// rectangles until the queue fills.
`default_nettype none
module ray_rect_nearest_hit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rrnh_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rrnh_pkg::out_t                out_data,
  input  logic                          cfg_we,
  input  logic [rrnh_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [rrnh_pkg::CW-1:0]       cfg_data
);
  import rrnh_pkg::*;

  ray_t       ray_r;
  logic       push_valid;
  edge_item_t push_data;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  edge_item_t q_data;

  // Ray registers: the user must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_X: ray_r.x1 <= $signed(cfg_data);
        REG_START_Y: ray_r.y1 <= $signed(cfg_data);
        REG_END_X:   ray_r.x2 <= $signed(cfg_data);
        REG_END_Y:   ray_r.y2 <= $signed(cfg_data);
        default:     ray_r    <= ray_r;
      endcase
    end
  end

  // Classify each edge of the incoming rectangle.
  rrnh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ray        (ray_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_data  (push_data),
    .q_full     (q_full)
  );

  // Decouple edge tests from the minimum search.
  rrnh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  // Keep the nearest hit and produce the rounded end point.
  rrnh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### dv/ray_rect_nearest_hit_tb.sv
// Self-checking testbench for the ray versus rectangle nearest hit block.
`timescale 1ns / 1ps
`default_nettype none
module ray_rect_nearest_hit_tb;
  import rrnh_pkg::*;

  localparam int  ITEMS      = 2000;
  localparam int  SETTLE     = 120;      // back end drain plus rounding divide
  localparam int  CYCLE_CAP  = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CW-1:0] cfg_data = '0;

  ray_rect_nearest_hit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the ray registers and the running nearest-t fraction.
  logic signed [CW-1:0] ray_x1, ray_y1, ray_x2, ray_y2;
  longint unsigned near_num, near_den;
  bit near_valid;

  out_t hit_points[$];   // expected end points, oldest first
  int   mismatches;
  int   items_sent;
  int   stall_pct;
  longint cycles;

  // Test one edge (x3,y3)-(x4,y4) against the ray; keep the smaller t.
  function automatic void cross_edge(longint x3, longint y3, longint x4, longint y4);
    longint x1, y1, dx, dy, ex, ey, nt, nu, d;
    logic [127:0] lhs, rhs;
    x1 = ray_x1;
    y1 = ray_y1;
    dx = x1 - longint'(ray_x2);
    dy = y1 - longint'(ray_y2);
    ex = x3 - x4;
    ey = y3 - y4;
    nt = (x1 - x3) * ey - (y1 - y3) * ex;
    nu = -(dx * (y1 - y3) - dy * (x1 - x3));
    d  = dx * ey - dy * ex;
    if (d == 0) return;
    if (d < 0) begin
      d = -d; nt = -nt; nu = -nu;
    end
    if (nt <= 0 || nt >= d || nu <= 0 || nu >= d) return;
    // compare nt/d against the kept fraction by cross-multiplication
    lhs = 128'(nt) * 128'(near_den);
    rhs = 128'(near_num) * 128'(d);
    if (!near_valid || lhs < rhs) begin
      near_num = nt;
      near_den = d;
      near_valid = 1'b1;
    end
  endfunction

  // Start point plus t times the ray delta, Q.8, rounded half away from zero.
  function automatic logic [OUTW-1:0] scale_point(longint origin, longint diff);
    longint unsigned mag, den, p, q, r, fr, off, base;
    mag  = (diff < 0) ? longint'(-diff) : diff;
    den  = (near_den != 0) ? near_den : 1;
    p    = near_num * mag;
    q    = p / den;
    r    = p % den;
    fr   = ((r << (FRAC_BITS + 1)) + den) / (den << 1);
    off  = (q << FRAC_BITS) + fr;
    base = longint'(origin) <<< FRAC_BITS;
    return (diff < 0) ? OUTW'(base - off) : OUTW'(base + off);
  endfunction

  // Fold one rectangle into the running minimum; answer on the last one.
  function automatic bit trace_rect(in_t rect, output out_t ans);
    longint l, t, r, b;
    l = rect.rect_left;
    t = rect.rect_top;
    r = l + longint'(rect.rect_width);
    b = t + longint'(rect.rect_height);
    cross_edge(l, t, r, t);
    cross_edge(l, t, l, b);
    cross_edge(r, t, r, b);
    cross_edge(l, b, r, b);
    ans = '0;
    if (!rect.last_rect) return 1'b0;
    if (near_valid) begin
      ans.hit_found = 1'b1;
      ans.end_x = scale_point(ray_x1, longint'(ray_x2) - longint'(ray_x1));
      ans.end_y = scale_point(ray_y1, longint'(ray_y2) - longint'(ray_y1));
    end else begin
      ans.hit_found = 1'b0;
      ans.end_x = OUTW'(longint'(ray_x2) <<< FRAC_BITS);
      ans.end_y = OUTW'(longint'(ray_y2) <<< FRAC_BITS);
    end
    near_num = 0;
    near_den = 1;
    near_valid = 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Write all four ray registers back to back; caller is just past an edge.
  task automatic load_ray(logic signed [CW-1:0] sx, logic signed [CW-1:0] sy,
                          logic signed [CW-1:0] ex, logic signed [CW-1:0] ey);
    cfg_reg_t idx;
    logic [CW-1:0] vals[4];
    vals[REG_START_X] = sx;
    vals[REG_START_Y] = sy;
    vals[REG_END_X]   = ex;
    vals[REG_END_Y]   = ey;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_t'(i);
      cfg_we   <= 1'b1;
      cfg_addr <= idx;
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ray_x1 = sx; ray_y1 = sy; ray_x2 = ex; ray_y2 = ey;
  endtask

  // Offer one rectangle and hold it until the transfer; predict on acceptance.
  task automatic send_rect(in_t rect, bit typed, out_t typed_ans);
    int gap;
    out_t ans;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rect;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (trace_rect(rect, ans)) begin
      // typed rows must also agree with the predictor
      if (typed && ans !== typed_ans) begin
        mismatches++;
        if (mismatches <= 10)
          $display("typed row disagrees: typed %h predicted %h", typed_ans, ans);
      end
      hit_points.insert(hit_points.size(), typed ? typed_ans : ans);
    end
  endtask

  // Hold off the sender until every answer is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (hit_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic in_t make_rect(bit aimed, bit last);
    in_t rect;
    longint px, py;
    int k, w, h;
    rect = in_t'($bits(in_t)'({$urandom, $urandom}));
    rect.last_rect = last;
    if (!aimed) return rect;
    w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
    h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 64);
    k = $urandom_range(0, 16);
    px = longint'(ray_x1) + ((longint'(ray_x2) - longint'(ray_x1)) * k) / 16;
    py = longint'(ray_y1) + ((longint'(ray_y2) - longint'(ray_y1)) * k) / 16;
    rect.rect_width  = SW'(w);
    rect.rect_height = SW'(h);
    rect.rect_left   = CW'(px - $urandom_range(0, w));
    rect.rect_top    = CW'(py - $urandom_range(0, h));
    return rect;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int mode);
    case (mode)
      0: return CW'($urandom_range(0, 400)) - 16'sd200;
      1: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      default: return CW'($urandom);
    endcase
  endfunction

  // Result side: compare each transfer with the oldest expected point.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (hit_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = hit_points.pop_front();
        if (out_data.hit_found !== want.hit_found || out_data.end_x !== want.end_x ||
            out_data.end_y !== want.end_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: hit %b/%b x %h/%h y %h/%h (expected/actual)",
                     want.hit_found, out_data.hit_found, want.end_x, out_data.end_x,
                     want.end_y, out_data.end_y);
        end
      end
    end
  end

  // Receiver backpressure, density changed per phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("ray_rect_nearest_hit regression: fail");
      $finish;
    end
  end

  typedef struct {
    in_t  rect;
    bit   typed;
    out_t ans;
  } table_row_t;

  initial begin
    table_row_t rows[$];
    out_t miss;
    int qlen, mode;
    logic signed [CW-1:0] sx, sy, ex, ey;
    mismatches = 0;
    items_sent = 0;
    cycles = 0;
    stall_pct = 0;
    near_num = 0; near_den = 1; near_valid = 1'b0;
    ray_x1 = '0; ray_y1 = '0; ray_x2 = '0; ray_y2 = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: zero-length ray, so nothing can be hit
    send_rect('{rect_left: -16'sd5, rect_top: -16'sd5, rect_width: 12'd10,
                rect_height: 12'd10, last_rect: 1'b1}, 1'b1, '0);
    drain();

    // ray along x from 0 to 100
    load_ray(16'sd0, 16'sd0, 16'sd100, 16'sd0);
    miss = '{hit_found: 1'b0, end_x: 24'sd25600, end_y: 24'sd0};
    rows = '{
      // far away: no crossing
      '{'{16'sd1000, 16'sd1000, 12'd10, 12'd10, 1'b1}, 1'b1, miss},
      // left edge crosses at t = 1/2
      '{'{16'sd50, -16'sd10, 12'd10, 12'd20, 1'b1}, 1'b1,
        '{hit_found: 1'b1, end_x: 24'sd12800, end_y: 24'sd0}},
      // point rectangle: every edge degenerate
      '{'{16'sd50, 16'sd0, 12'd0, 12'd0, 1'b1}, 1'b1, miss},
      // edge ends on the ray, top edge lies on it
      '{'{16'sd50, 16'sd0, 12'd10, 12'd10, 1'b1}, 1'b1, miss},
      // crossing exactly at the ray's end
      '{'{16'sd100, -16'sd5, 12'd10, 12'd10, 1'b1}, 1'b1, miss},
      // field extremes, spread over one query
      '{'{-16'sd32768, -16'sd32768, 12'd4095, 12'd4095, 1'b0}, 1'b0, miss},
      '{'{16'sd32767, 16'sd32767, 12'd4095, 12'd4095, 1'b1}, 1'b1, miss},
      // several rectangles, nearest wins, ties in t between edges
      '{'{16'sd70, -16'sd3, 12'd5, 12'd6, 1'b0}, 1'b0, miss},
      '{'{16'sd20, -16'sd1, 12'd0, 12'd7, 1'b0}, 1'b0, miss},
      '{'{16'sd20, -16'sd9, 12'd30, 12'd10, 1'b0}, 1'b0, miss},
      '{'{16'sd90, -16'sd40, 12'd4095, 12'd4095, 1'b1}, 1'b0, miss},
      // width zero: left and right edges coincide
      '{'{16'sd33, -16'sd2, 12'd0, 12'd3, 1'b1}, 1'b0, miss}
    };
    foreach (rows[i]) send_rect(rows[i].rect, rows[i].typed, rows[i].ans);
    drain();

    // diagonal ray with inexact rounding
    load_ray(-16'sd7, 16'sd3, 16'sd31, -16'sd17);
    send_rect('{16'sd0, -16'sd20, 12'd3, 12'd40, 1'b0}, 1'b0, miss);
    send_rect('{16'sd11, -16'sd9, 12'd5, 12'd2, 1'b1}, 1'b0, miss);
    drain();

    // random phases: new ray, then queries of aimed rectangles with some noise
    while (items_sent < ITEMS) begin
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 75;
      endcase
      mode = $urandom_range(0, 9);
      mode = (mode < 6) ? 0 : (mode < 7) ? 1 : 2;
      sx = pick_coord(mode);
      sy = pick_coord(mode);
      ex = pick_coord(mode);
      ey = pick_coord(mode);
      if ($urandom_range(0, 15) == 0) begin
        ex = sx;   // zero-length ray
        ey = sy;
      end
      load_ray(sx, sy, ex, ey);
      for (int qi = 0; qi < 6; qi++) begin
        qlen = $urandom_range(1, 8);
        for (int ri = 0; ri < qlen; ri++)
          send_rect(make_rect($urandom_range(0, 99) < 85, ri == qlen - 1), 1'b0, miss);
      end
      drain();
    end

    stall_pct = 0;
    drain();
    if (mismatches == 0) begin
      $display("ray_rect_nearest_hit regression: pass");
    end else begin
      $display("ray_rect_nearest_hit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
